[rtl/core/assert_macros.svh]
// Assertion macros shared by the keystream generator RTL.
// Self-contained; the synthesis build defines SYNTH to drop the checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define A51KG_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("a51kg same-cycle check failed");
`define A51KG_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("a51kg next-cycle check failed");
`else
`define A51KG_ASSERT_IMPL(lbl, clk, rst, ante, cons)
`define A51KG_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

[rtl/core/a51kg_pkg.sv]
// Shared types and constants for the A5/1 keystream generator.
// No dependencies.
package a51kg_pkg;

   localparam int R1_LEN = 19;
   localparam int R2_LEN = 22;
   localparam int R3_LEN = 23;

   localparam int KEY_W   = 64;
   localparam int FRAME_W = 22;
   localparam int REQ_DATA_W = 24;
   localparam int RSP_DATA_W = 16;
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 64;

   localparam logic [6:0] LOAD_LAST  = 7'd85;   // 64 key + 22 frame steps
   localparam logic [6:0] MIX_LAST   = 7'd99;   // 100 mixing steps
   localparam logic [2:0] BIT_LAST   = 3'd7;
   localparam logic [2:0] TAIL_LAST  = 3'd1;    // short final byte holds 2 bits
   localparam logic [3:0] BYTE_LAST  = 4'd14;
   localparam logic       CSR_IDX_KEY = 1'b0;

   typedef struct packed {
      logic clear;
      logic step;
      logic majority;
      logic in_bit;
   } lfsr_ctrl_type;

endpackage

[rtl/core/a51kg_lfsr_core.sv]
// Three A5/1 shift registers taking one step per cycle while ctrl.step is set, plain or majority clocked.
// Depends on a51kg_pkg.
module a51kg_lfsr_core
   import a51kg_pkg::*;
(
   input  logic          clock,
   input  lfsr_ctrl_type ctrl,
   output logic          ks_bit
);

   logic [R1_LEN-1:0] r1_ff, r1_in;
   logic [R2_LEN-1:0] r2_ff, r2_in;
   logic [R3_LEN-1:0] r3_ff, r3_in;
   logic [R1_LEN-1:0] r1_sh;
   logic [R2_LEN-1:0] r2_sh;
   logic [R3_LEN-1:0] r3_sh;
   logic c1, c2, c3, maj;
   logic en1, en2, en3;

   always_comb begin
      r1_sh = {r1_ff[R1_LEN-2:0], r1_ff[18] ^ r1_ff[17] ^ r1_ff[16] ^ r1_ff[13]};
      r2_sh = {r2_ff[R2_LEN-2:0], r2_ff[21] ^ r2_ff[20]};
      r3_sh = {r3_ff[R3_LEN-2:0], r3_ff[22] ^ r3_ff[21] ^ r3_ff[20] ^ r3_ff[7]};
      c1  = r1_ff[8];
      c2  = r2_ff[10];
      c3  = r3_ff[10];
      maj = (c1 & c2) | (c1 & c3) | (c2 & c3);
      en1 = ctrl.step && (!ctrl.majority || (c1 == maj));
      en2 = ctrl.step && (!ctrl.majority || (c2 == maj));
      en3 = ctrl.step && (!ctrl.majority || (c3 == maj));
      r1_in = r1_ff;
      r2_in = r2_ff;
      r3_in = r3_ff;
      if (ctrl.clear) begin
         r1_in = '0;
         r2_in = '0;
         r3_in = '0;
      end else begin
         if (en1) begin
            r1_in = r1_sh ^ {{(R1_LEN-1){1'b0}}, ctrl.in_bit};
         end
         if (en2) begin
            r2_in = r2_sh ^ {{(R2_LEN-1){1'b0}}, ctrl.in_bit};
         end
         if (en3) begin
            r3_in = r3_sh ^ {{(R3_LEN-1){1'b0}}, ctrl.in_bit};
         end
      end
      ks_bit = r1_in[R1_LEN-1] ^ r2_in[R2_LEN-1] ^ r3_in[R3_LEN-1];
   end

   always_ff @(posedge clock) begin
      r1_ff <= r1_in;
      r2_ff <= r2_in;
      r3_ff <= r3_in;
   end

endmodule

[rtl/core/a51_keystream_generator_top.sv]
// A5/1 keystream generator: one frame number in, two 114-bit blocks out as bytes.
// Depends on a51kg_pkg, a51kg_lfsr_core and assert_macros.svh.
//
// Usage:
//  - Write the 64-bit session key at csr address 0 while the block is idle.
//  - Each req request carries a 22-bit frame number; req_tready is high only
//    when no frame is in progress.
//  - Per frame the shared LFSR steps once per cycle unless output stalls: 86 load
//    steps (key, then frame), 100 mixing steps, then 228 keystream steps.
//  - 30 rsp requests follow: block 0 bytes 0..14, then block 1 bytes 0..14;
//    byte 14 carries two bits in its top positions, tlast marks the final one.
//  - The first byte is offered once load, mixing and its keystream steps are
//    done; a new frame is accepted only after the last byte is registered.
//  - One output register decouples the sides; when it is still full as a
//    byte completes, the LFSR unit holds until the receiver takes it.
//  - Reset clears the key to zero and returns the sequencer to idle.
`include "assert_macros.svh"
module a51_keystream_generator_top
   import a51kg_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,   // [21:0] frame_number, [23:22] zero
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,   // [3:0] byte_index, [11:4] stream_byte
   output logic                  rsp_tuser,   // [0] block_select
   output logic                  rsp_tlast,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_LOAD = 2'd1;
   localparam logic [1:0] ST_MIX  = 2'd2;
   localparam logic [1:0] ST_OUT  = 2'd3;

   logic [1:0]                 state_ff, state_in;
   logic [6:0]                 step_cnt_ff, step_cnt_in;
   logic [2:0]                 bit_cnt_ff, bit_cnt_in;
   logic [3:0]                 byte_cnt_ff, byte_cnt_in;
   logic                       block_ff, block_in;
   logic [6:0]                 acc_ff, acc_in;
   logic [KEY_W+FRAME_W-1:0]   load_sr_ff, load_sr_in;
   logic [KEY_W-1:0]           key_ff, key_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [7:0]                 rsp_byte_ff, rsp_byte_in;
   logic [3:0]                 rsp_idx_ff, rsp_idx_in;
   logic                       rsp_blk_ff, rsp_blk_in;
   logic                       rsp_last_ff, rsp_last_in;
   lfsr_ctrl_type              ctrl;
   logic                       ks_bit;
   logic                       req_fire, out_free, last_bit, can_step, key_wr;

   a51kg_lfsr_core u_lfsr (
      .clock  (clock),
      .ctrl   (ctrl),
      .ks_bit (ks_bit)
   );

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign last_bit   = (bit_cnt_ff == BIT_LAST) ||
                       ((byte_cnt_ff == BYTE_LAST) && (bit_cnt_ff == TAIL_LAST));
   assign can_step   = !last_bit || out_free;

   assign csr_pready = 1'b1;
   assign key_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready &&
                       (csr_paddr[3] == CSR_IDX_KEY);
   assign csr_prdata = (csr_paddr[3] == CSR_IDX_KEY) ? key_ff : '0;
   assign key_in     = key_wr ? csr_pwdata : key_ff;

   always_comb begin
      state_in     = state_ff;
      step_cnt_in  = step_cnt_ff;
      bit_cnt_in   = bit_cnt_ff;
      byte_cnt_in  = byte_cnt_ff;
      block_in     = block_ff;
      acc_in       = acc_ff;
      load_sr_in   = load_sr_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_byte_in  = rsp_byte_ff;
      rsp_idx_in   = rsp_idx_ff;
      rsp_blk_in   = rsp_blk_ff;
      rsp_last_in  = rsp_last_ff;
      ctrl         = '{clear: 1'b0, step: 1'b0, majority: 1'b0, in_bit: 1'b0};
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               ctrl.clear  = 1'b1;
               load_sr_in  = {req_tdata[FRAME_W-1:0], key_ff};
               step_cnt_in = '0;
               state_in    = ST_LOAD;
            end
         end
         ST_LOAD: begin
            ctrl.step   = 1'b1;
            ctrl.in_bit = load_sr_ff[0];
            load_sr_in  = {1'b0, load_sr_ff[KEY_W+FRAME_W-1:1]};
            step_cnt_in = step_cnt_ff + 7'd1;
            if (step_cnt_ff == LOAD_LAST) begin
               step_cnt_in = '0;
               state_in    = ST_MIX;
            end
         end
         ST_MIX: begin
            ctrl.step     = 1'b1;
            ctrl.majority = 1'b1;
            step_cnt_in   = step_cnt_ff + 7'd1;
            if (step_cnt_ff == MIX_LAST) begin
               bit_cnt_in  = '0;
               byte_cnt_in = '0;
               block_in    = 1'b0;
               state_in    = ST_OUT;
            end
         end
         ST_OUT: begin
            if (can_step) begin
               ctrl.step     = 1'b1;
               ctrl.majority = 1'b1;
               acc_in        = {acc_ff[5:0], ks_bit};
               if (last_bit) begin
                  rsp_valid_in = 1'b1;
                  rsp_idx_in   = byte_cnt_ff;
                  rsp_blk_in   = block_ff;
                  rsp_last_in  = 1'b0;
                  bit_cnt_in   = '0;
                  if (byte_cnt_ff == BYTE_LAST) begin
                     rsp_byte_in = {acc_ff[0], ks_bit, 6'b0};
                     byte_cnt_in = '0;
                     block_in    = 1'b1;
                     if (block_ff) begin
                        rsp_last_in = 1'b1;
                        state_in    = ST_IDLE;
                     end
                  end else begin
                     rsp_byte_in = {acc_ff, ks_bit};
                     byte_cnt_in = byte_cnt_ff + 4'd1;
                  end
               end else begin
                  bit_cnt_in = bit_cnt_ff + 3'd1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_cnt_ff  <= '0;
         bit_cnt_ff   <= '0;
         byte_cnt_ff  <= '0;
         block_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
         key_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         step_cnt_ff  <= step_cnt_in;
         bit_cnt_ff   <= bit_cnt_in;
         byte_cnt_ff  <= byte_cnt_in;
         block_ff     <= block_in;
         rsp_valid_ff <= rsp_valid_in;
         key_ff       <= key_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff      <= acc_in;
      load_sr_ff  <= load_sr_in;
      rsp_byte_ff <= rsp_byte_in;
      rsp_idx_ff  <= rsp_idx_in;
      rsp_blk_ff  <= rsp_blk_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'b0, rsp_byte_ff, rsp_idx_ff};
   assign rsp_tuser  = rsp_blk_ff;
   assign rsp_tlast  = rsp_last_ff;

   `A51KG_ASSERT_NEXT(a_start_load, clock, reset, req_fire, (state_ff == ST_LOAD) && (step_cnt_ff == 7'd0))
   `A51KG_ASSERT_NEXT(a_hold_on_stall, clock, reset, (state_ff == ST_OUT) && last_bit && rsp_valid_ff && !rsp_tready, $stable(bit_cnt_ff) && $stable(byte_cnt_ff) && $stable(rsp_byte_ff))
   `A51KG_ASSERT_IMPL(a_last_tag, clock, reset, rsp_valid_ff && rsp_last_ff, rsp_blk_ff && (rsp_idx_ff == BYTE_LAST))
   `A51KG_ASSERT_IMPL(a_tail_pad, clock, reset, rsp_valid_ff && (rsp_idx_ff == BYTE_LAST), rsp_byte_ff[5:0] == 6'b0)

endmodule

[tb/sv/a51_keystream_generator_top_test.sv]
// Self-checking testbench for a51_keystream_generator_top: drives frame-number
// requests and session-key writes, predicts each frame's 30 keystream bytes.
// Depends on a51kg_pkg and the generator RTL.
`timescale 1ns / 100ps

module a51_keystream_generator_top_test;
   import a51kg_pkg::*;

   localparam logic [CSR_ADDR_W-1:0] KEY_ADDR          = 4'd0;
   localparam logic [CSR_ADDR_W-1:0] UNMAPPED_ADDR     = 4'd8;
   localparam logic [FRAME_W-1:0]    FRAME_MAX         = 22'h3fffff;
   localparam int                    BYTES_PER_BLOCK   = 15;
   localparam int                    BITS_PER_BLOCK    = 114;
   localparam int                    MIX_STEPS         = 100;

   typedef struct {
      logic       block;
      logic [3:0] index;
      logic [7:0] kbyte;
      logic       last;
   } ks_byte_type;

   class keystream_scoreboard;
      logic [KEY_W-1:0] key;
      logic [18:0]      r1;
      logic [21:0]      r2;
      logic [22:0]      r3;
      ks_byte_type      pending_bytes[$];
      int               errors;
      int               bytes_checked;
      int               frames_noted;

      function new();
         key = '0;
         errors = 0;
         bytes_checked = 0;
         frames_noted = 0;
      endfunction

      function void set_key(logic [KEY_W-1:0] value);
         key = value;
      endfunction

      function void step_r1(logic in_bit);
         r1 = {r1[17:0], r1[18] ^ r1[17] ^ r1[16] ^ r1[13] ^ in_bit};
      endfunction

      function void step_r2(logic in_bit);
         r2 = {r2[20:0], r2[21] ^ r2[20] ^ in_bit};
      endfunction

      function void step_r3(logic in_bit);
         r3 = {r3[21:0], r3[22] ^ r3[21] ^ r3[20] ^ r3[7] ^ in_bit};
      endfunction

      function logic majority_step();
         logic c1, c2, c3, maj;
         c1 = r1[8];
         c2 = r2[10];
         c3 = r3[10];
         maj = (c1 & c2) | (c1 & c3) | (c2 & c3);
         if (c1 == maj) step_r1(1'b0);
         if (c2 == maj) step_r2(1'b0);
         if (c3 == maj) step_r3(1'b0);
         return r1[18] ^ r2[21] ^ r3[22];
      endfunction

      function void note_frame(logic [FRAME_W-1:0] frame);
         logic [7:0]  blocks [2][BYTES_PER_BLOCK];
         logic        in_bit;
         logic        ks;
         int          i;
         int          b;
         ks_byte_type e;
         r1 = '0;
         r2 = '0;
         r3 = '0;
         for (i = 0; i < KEY_W + FRAME_W; i++) begin
            in_bit = (i < KEY_W) ? key[i] : frame[i - KEY_W];
            step_r1(in_bit);
            step_r2(in_bit);
            step_r3(in_bit);
         end
         for (i = 0; i < MIX_STEPS; i++)
            ks = majority_step();
         for (b = 0; b < 2; b++) begin
            for (i = 0; i < BYTES_PER_BLOCK; i++)
               blocks[b][i] = 8'h00;
            for (i = 0; i < BITS_PER_BLOCK; i++) begin
               ks = majority_step();
               blocks[b][i / 8][7 - (i % 8)] = ks;
            end
         end
         for (b = 0; b < 2; b++) begin
            for (i = 0; i < BYTES_PER_BLOCK; i++) begin
               e.block = b[0];
               e.index = i[3:0];
               e.kbyte = blocks[b][i];
               e.last  = (b == 1 && i == BYTES_PER_BLOCK - 1);
               pending_bytes.push_back(e);
            end
         end
         frames_noted++;
      endfunction

      function void check_byte(logic blk, logic [3:0] idx, logic [7:0] kb, logic last);
         ks_byte_type e;
         if (pending_bytes.size() == 0) begin
            $error("keystream byte with nothing expected: block %0d index %0d byte %h",
                   blk, idx, kb);
            errors++;
            return;
         end
         e = pending_bytes.pop_front();
         bytes_checked++;
         if (blk !== e.block) begin
            $error("block_select: expected %0d, actual %0d", e.block, blk);
            errors++;
         end
         if (idx !== e.index) begin
            $error("byte_index: expected %0d, actual %0d", e.index, idx);
            errors++;
         end
         if (kb !== e.kbyte) begin
            $error("stream_byte: expected %h, actual %h", e.kbyte, kb);
            errors++;
         end
         if (last !== e.last) begin
            $error("last_of_run: expected %0d, actual %0d", e.last, last);
            errors++;
         end
      endfunction
   endclass

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tuser;
   logic                  rsp_tlast;
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   keystream_scoreboard sb;
   int send_idle_pct = 0;
   int sink_idle_pct = 0;
   int keys_loaded = 0;

   a51_keystream_generator_top dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         sb.check_byte(rsp_tuser, rsp_tdata[3:0], rsp_tdata[11:4], rsp_tlast);
   end

   // receiver backpressure
   initial begin
      forever begin
         @(posedge clock);
         if (sink_idle_pct != 0 && $urandom_range(99) < sink_idle_pct) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clock);
         end
         rsp_tready <= 1'b1;
      end
   end

   task csr_write(input logic [CSR_ADDR_W-1:0] addr, input logic [CSR_DATA_W-1:0] data);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= addr;
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task csr_check_key();
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= KEY_ADDR;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      if (csr_prdata !== sb.key) begin
         $error("session_key: expected %h, actual %h", sb.key, csr_prdata);
         sb.errors++;
      end
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task load_key(input logic [KEY_W-1:0] value);
      csr_write(KEY_ADDR, value);
      sb.set_key(value);
      keys_loaded++;
      @(posedge clock);
      csr_check_key();
      @(posedge clock);
   endtask

   task send_frame(input logic [FRAME_W-1:0] frame);
      if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 18)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {{(REQ_DATA_W - FRAME_W){1'b0}}, frame};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.note_frame(frame);
   endtask

   task wait_drained();
      req_tvalid <= 1'b0;
      while (sb.pending_bytes.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   initial begin
      logic [FRAME_W-1:0] frame;
      logic [FRAME_W-1:0] prev_frame;
      logic [KEY_W-1:0]   key;
      int                 phase;
      int                 n;
      sb = new();
      prev_frame = '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // directed: zero and all-ones extremes, unmapped register, repeated frames
      send_idle_pct = 20;
      sink_idle_pct = 6;
      load_key(64'h0);
      send_frame(22'h000000);
      send_frame(FRAME_MAX);
      wait_drained();
      load_key({KEY_W{1'b1}});
      send_frame(22'h000000);
      send_frame(FRAME_MAX);
      send_frame(22'h2aaaaa);
      send_frame(22'h155555);
      send_frame(22'h000001);
      send_frame(22'h200000);
      wait_drained();
      load_key(64'h8000_0000_0000_0001);
      csr_write(UNMAPPED_ADDR, {$urandom, $urandom});
      @(posedge clock);
      csr_check_key();
      @(posedge clock);
      send_frame(22'h123456);
      send_frame(22'h123456);
      send_frame(22'h0abcde);
      wait_drained();
      load_key(64'h0123_4567_89ab_cdef);
      send_frame(22'h000134);
      send_frame(22'h000134);
      send_frame(22'h3c0f0f);
      wait_drained();

      for (phase = 0; phase < 8; phase++) begin
         case ($urandom_range(9))
            0:       key = '0;
            1:       key = '1;
            default: key = {$urandom, $urandom};
         endcase
         if (phase == 7 || phase == 2) begin
            send_idle_pct = 0;
            sink_idle_pct = 0;
         end else begin
            send_idle_pct = $urandom_range(10, 60);
            sink_idle_pct = $urandom_range(2, 15);
         end
         load_key(key);
         for (n = 0; n < 54; n++) begin
            if (phase == 3 && n == 27)
               wait_drained();
            case ($urandom_range(19))
               0:       frame = '0;
               1:       frame = FRAME_MAX;
               2, 3:    frame = prev_frame;
               default: frame = FRAME_W'($urandom_range(0, FRAME_MAX));
            endcase
            send_frame(frame);
            prev_frame = frame;
         end
         wait_drained();
      end

      repeat (20) @(posedge clock);
      $display("Covered %0d frames under %0d session keys, %0d keystream bytes compared.",
               sb.frames_noted, keys_loaded, sb.bytes_checked);
      $display("Directed extremes, unmapped register write and repeated frames included.");
      if (sb.errors == 0 && sb.pending_bytes.size() == 0) begin
         $display("end of test: clean");
      end else begin
         if (sb.pending_bytes.size() != 0)
            $error("%0d keystream bytes never arrived", sb.pending_bytes.size());
         $display("end of test: mismatches");
      end
      $finish;
   end

   initial begin
      #6_000_000;
      $display("end of test: mismatches");
      $finish;
   end

endmodule

[sim.f]
+incdir+rtl/core
rtl/core/a51kg_pkg.sv
rtl/core/a51kg_lfsr_core.sv
rtl/core/a51_keystream_generator_top.sv
tb/sv/a51_keystream_generator_top_test.sv
